// ===== design/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, sizes and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int POOL_BYTES   = 4096;
	localparam int HEADER_BYTES = 8;

	localparam int IDX_W  = $clog2(POOL_BYTES);
	localparam int SPAN_W = IDX_W + 1;
	localparam int REQ_W  = 13;
	localparam int SIZE_W = 13;
	localparam int CW     = ((SPAN_W > REQ_W) ? SPAN_W : REQ_W) + 1;
	localparam int ADDR_W = 32;
	localparam int STAT_W = 2;
	localparam int DATA_W = 32;
	localparam int APB_AW = 3;

	localparam int SIZE_RESET = 4096;

	// block marks
	localparam int MARK_W         = 2;
	localparam int MARK_START_BIT = 0;
	localparam int MARK_FREE_BIT  = 1;
	localparam logic [MARK_W-1:0] MK_NONE = 2'b00;
	localparam logic [MARK_W-1:0] MK_USED = 2'b01;
	localparam logic [MARK_W-1:0] MK_FREE = 2'b11;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	// datapath commands
	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_NOP     = 4'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_A_SCAN  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_A_SPLIT = 4'd4;
	localparam logic [CMD_W-1:0] CMD_A_MARK  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_F_CHK   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_F_FWD   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_F_BWD   = 4'd8;

	typedef struct packed {
		logic              op;
		logic [REQ_W-1:0]  req_size;
		logic [ADDR_W-1:0] address;
	} ffba_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [STAT_W-1:0] status;
	} ffba_out_t;

	typedef struct packed {
		logic [CMD_W-1:0] act;
		logic             out_load;
	} ffba_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic found;
		logic fail;
		logic bad;
		logic fwd_stop;
		logic off_zero;
		logic bwd_done;
	} ffba_sts_t;

endpackage

// ===== design/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer of the allocator: clearing pass, allocate walk, free and merge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                size_wr,
	input  ffba_pkg::ffba_sts_t sts,
	output ffba_pkg::ffba_cmd_t cmd
);
	import ffba_pkg::*;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_A_SCAN  = 4'd2;
	localparam logic [3:0] S_A_SPLIT = 4'd3;
	localparam logic [3:0] S_A_MARK  = 4'd4;
	localparam logic [3:0] S_F_CHK   = 4'd5;
	localparam logic [3:0] S_F_FWD   = 4'd6;
	localparam logic [3:0] S_F_BWD   = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.act      = CMD_NOP;
		cmd.out_load = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.act = CMD_CLEAR;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = CMD_LOAD;
					state_d = (in_op == OP_FREE) ? S_F_CHK : S_A_SCAN;
				end
			end
			S_A_SCAN: begin
				cmd.act = CMD_A_SCAN;
				if (sts.found) begin
					state_d = S_A_SPLIT;
				end else if (sts.fail) begin
					state_d = S_FIN;
				end
			end
			S_A_SPLIT: begin
				cmd.act = CMD_A_SPLIT;
				state_d = S_A_MARK;
			end
			S_A_MARK: begin
				cmd.act = CMD_A_MARK;
				state_d = S_FIN;
			end
			S_F_CHK: begin
				cmd.act = CMD_F_CHK;
				state_d = sts.bad ? S_FIN : S_F_FWD;
			end
			S_F_FWD: begin
				cmd.act = CMD_F_FWD;
				if (sts.fwd_stop) begin
					state_d = sts.off_zero ? S_FIN : S_F_BWD;
				end
			end
			S_F_BWD: begin
				cmd.act = CMD_F_BWD;
				if (sts.bwd_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (size_wr) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ffba_dp.sv =====
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: configuration registers, mark memory, walk pointers,
// block evaluation and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ffba_pkg::ffba_cmd_t               cmd,
	output ffba_pkg::ffba_sts_t               sts,
	input  ffba_pkg::ffba_in_t                in_data,
	output ffba_pkg::ffba_out_t               out_data,
	input  logic                              base_wr,
	input  logic                              size_wr,
	input  logic                              reg_sel,
	input  logic [ffba_pkg::DATA_W-1:0]       wdata,
	output logic [ffba_pkg::DATA_W-1:0]       cfg_rdata
);
	import ffba_pkg::*;

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [SPAN_W-1:0] idx_q;

	logic [REQ_W-1:0]  req_q;
	logic [IDX_W-1:0]  off_lo_q;
	logic              off_oob_q;
	logic [IDX_W-1:0]  blk_s_q;
	logic              blk_free_q;
	logic              split_q;
	logic [IDX_W-1:0]  cur_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [STAT_W-1:0] res_status_q;
	ffba_out_t         out_q;

	logic [CW-1:0]     size_w;
	logic [SPAN_W-1:0] span_c;
	logic [ADDR_W-1:0] off32;
	logic              oob;
	logic [MARK_W-1:0] mark_rd;
	logic              rd_start;
	logic              rd_free;
	logic              at_end;
	logic              boundary;
	logic [CW-1:0]     len;
	logic [CW-1:0]     pay;
	logic [CW-1:0]     req_w;
	logic              fit;
	logic              split_c;
	logic              found;
	logic              fail;
	logic [CW-1:0]     ns_c;
	logic              bad;
	logic              fwd_stop;
	logic              p_hit;
	logic [SPAN_W-1:0] idx_inc;
	logic [SPAN_W-1:0] idx_dec;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_wa;
	logic [MARK_W-1:0] ram_wd;
	logic [IDX_W-1:0]  ram_ra;

	// span in use
	always_comb begin
		size_w = CW'(size_q);
		if (size_w < CW'(HEADER_BYTES + 1)) begin
			span_c = SPAN_W'(HEADER_BYTES + 1);
		end else if (size_w > CW'(POOL_BYTES)) begin
			span_c = SPAN_W'(POOL_BYTES);
		end else begin
			span_c = SPAN_W'(size_w);
		end
	end

	assign off32 = in_data.address - base_q - ADDR_W'(HEADER_BYTES);
	assign oob   = off32 >= ADDR_W'(span_c);

	assign rd_start = mark_rd[MARK_START_BIT];
	assign rd_free  = mark_rd[MARK_FREE_BIT];
	assign at_end   = (idx_q == span_c);
	assign boundary = at_end || rd_start;
	assign idx_inc  = idx_q + SPAN_W'(1);
	assign idx_dec  = idx_q - SPAN_W'(1);

	// block evaluation
	assign len     = CW'(idx_q) - CW'(blk_s_q);
	assign pay     = (len >= CW'(HEADER_BYTES)) ? (len - CW'(HEADER_BYTES)) : '0;
	assign req_w   = CW'(req_q);
	assign fit     = (pay >= req_w);
	assign split_c = (pay > (CW'(HEADER_BYTES) + req_w));
	assign found   = boundary && (idx_q != '0) && blk_free_q && fit;
	assign fail    = at_end && !found;
	assign ns_c    = CW'(blk_s_q) + CW'(HEADER_BYTES) + req_w;

	// free checks
	assign bad      = off_oob_q || !rd_start;
	assign fwd_stop = at_end || (rd_start && !rd_free);
	assign p_hit    = (idx_q == '0) || rd_start;

	assign sts.clear_last = (idx_q[IDX_W-1:0] == IDX_W'(POOL_BYTES - 1));
	assign sts.found      = found;
	assign sts.fail       = fail;
	assign sts.bad        = bad;
	assign sts.fwd_stop   = fwd_stop;
	assign sts.off_zero   = (off_lo_q == '0);
	assign sts.bwd_done   = p_hit && (!rd_free || (idx_q == '0));

	assign cfg_rdata = (reg_sel == REG_SIZE) ? DATA_W'(size_q) : base_q;
	assign out_data  = out_q;

	// mark memory ports
	always_comb begin
		ram_we = 1'b0;
		ram_wa = idx_q[IDX_W-1:0];
		ram_wd = MK_NONE;
		ram_ra = '0;
		case (cmd.act)
			CMD_CLEAR: begin
				ram_we = 1'b1;
				ram_wd = (idx_q == '0) ? MK_FREE : MK_NONE;
			end
			CMD_LOAD: begin
				ram_ra = (in_data.op == OP_FREE) ? off32[IDX_W-1:0] : '0;
			end
			CMD_A_SCAN: begin
				ram_ra = idx_inc[IDX_W-1:0];
			end
			CMD_A_SPLIT: begin
				ram_we = split_q;
				ram_wa = ns_c[IDX_W-1:0];
				ram_wd = MK_FREE;
			end
			CMD_A_MARK: begin
				ram_we = 1'b1;
				ram_wa = blk_s_q;
				ram_wd = MK_USED;
			end
			CMD_F_CHK: begin
				ram_we = !bad;
				ram_wa = off_lo_q;
				ram_wd = MK_FREE;
				ram_ra = off_lo_q + IDX_W'(1);
			end
			CMD_F_FWD: begin
				ram_we = !at_end && rd_start && rd_free;
				ram_ra = fwd_stop ? (off_lo_q - IDX_W'(1)) : idx_inc[IDX_W-1:0];
			end
			CMD_F_BWD: begin
				ram_we = p_hit && rd_free;
				ram_wa = cur_q;
				ram_ra = idx_dec[IDX_W-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(MARK_W),
		.DEPTH(POOL_BYTES)
	) u_marks (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(ram_ra),
		.rdata(mark_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= SIZE_W'(SIZE_RESET);
			idx_q  <= '0;
		end else begin
			if (base_wr) begin
				base_q <= wdata;
			end
			if (size_wr) begin
				size_q <= wdata[SIZE_W-1:0];
				idx_q  <= '0;
			end else begin
				case (cmd.act)
					CMD_CLEAR: idx_q <= idx_inc;
					CMD_LOAD:  idx_q <= '0;
					CMD_A_SCAN: begin
						if (!found && !fail) begin
							idx_q <= idx_inc;
						end
					end
					CMD_F_CHK: idx_q <= SPAN_W'(off_lo_q) + SPAN_W'(1);
					CMD_F_FWD: idx_q <= fwd_stop ? (SPAN_W'(off_lo_q) - SPAN_W'(1)) : idx_inc;
					CMD_F_BWD: idx_q <= idx_dec;
					default:   idx_q <= idx_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			CMD_LOAD: begin
				req_q      <= in_data.req_size;
				off_lo_q   <= off32[IDX_W-1:0];
				off_oob_q  <= oob;
				blk_s_q    <= '0;
				blk_free_q <= 1'b0;
			end
			CMD_A_SCAN: begin
				if (found) begin
					split_q <= split_c;
				end else if (fail) begin
					res_addr_q   <= '0;
					res_status_q <= ST_NO_FIT;
				end else if (boundary) begin
					blk_s_q    <= idx_q[IDX_W-1:0];
					blk_free_q <= rd_free;
				end
			end
			CMD_A_MARK: begin
				res_addr_q   <= base_q + ADDR_W'(blk_s_q) + ADDR_W'(HEADER_BYTES);
				res_status_q <= ST_DONE;
			end
			CMD_F_CHK: begin
				cur_q        <= off_lo_q;
				res_addr_q   <= '0;
				res_status_q <= bad ? ST_NOT_FOUND : ST_DONE;
			end
			CMD_F_BWD: begin
				if (p_hit && rd_free) begin
					cur_q <= idx_q[IDX_W-1:0];
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
		if (cmd.out_load) begin
			out_q.result_address <= res_addr_q;
			out_q.status         <= res_status_q;
		end
	end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Allocate: walks the block marks from offset 0 to the first free block that
// fits, splits off the remainder when it exceeds a header, marks it used, else no fit.
// Free: marks the block free, walks forward to the next used block and back to the
// previous used block; one block mark is read per cycle from the mark memory.
// One transaction in flight; a waiting result stalls input.
// Reset and every pool_size write start a clearing pass over all 4096 marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ffba_pkg::ffba_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ffba_pkg::ffba_out_t           out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffba_pkg::APB_AW-1:0]   paddr,
	input  logic [ffba_pkg::DATA_W-1:0]   pwdata,
	output logic [ffba_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ffba_pkg::*;

	ffba_cmd_t cmd;
	ffba_sts_t sts;
	logic      apb_wr;
	logic      reg_sel;
	logic      base_wr;
	logic      size_wr;

	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[2];
	assign base_wr = apb_wr && (reg_sel == REG_BASE);
	assign size_wr = apb_wr && (reg_sel == REG_SIZE);

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_op    (in_data.op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.size_wr  (size_wr),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffba_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_data (out_data),
		.base_wr  (base_wr),
		.size_wr  (size_wr),
		.reg_sel  (reg_sel),
		.wdata    (pwdata),
		.cfg_rdata(prdata)
	);

endmodule
